FILE: src/ba_pkg.sv
// Shared types and codes for the buddy allocator.
// Holds the request and response transfer structs and the status and mode codes.
// No dependencies.
package ba_pkg;

   localparam int BLK_W  = 16;
   localparam int BYTE_W = 23;

   // Request modes.
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // Response status codes.
   localparam logic [1:0] STATUS_OK           = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE     = 2'd1;
   localparam logic [1:0] STATUS_BAD_SIZE     = 2'd2;
   localparam logic [1:0] STATUS_FREE_IGNORED = 2'd3;

   typedef struct packed {
      logic        mode;
      logic [23:0] request_size;
      logic [14:0] block_index;
   } ba_req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [14:0]       granted_index;
      logic [3:0]        granted_order;
      logic [BLK_W-1:0]  free_blocks;
      logic [BYTE_W-1:0] free_bytes;
      logic [BLK_W-1:0]  allocated_blocks;
      logic [BYTE_W-1:0] allocated_bytes;
   } ba_rsp_type;

endpackage

FILE: src/buddy_allocator.sv
// One request at a time; the next is taken in idle, which starts as the response is raised.
// Reset: synchronous, active high; afterwards a clearing pass writes one mask entry per cycle for all
// TOP_BLOCKS * (2^(TOP_ORDER+1) - 2) nodes (65472 at the defaults) before requests are taken.
// Depends on ba_pkg for the transfer structs and codes.
module buddy_allocator
   import ba_pkg::*;
#(
   parameter int TOP_BLOCKS      = 32,
   parameter int TOP_ORDER       = 10,
   parameter int MIN_BLOCK_BYTES = 128,
   parameter int HEADER_BYTES    = 40
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  ba_req_type req_payload,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output ba_rsp_type rsp_payload
);

   localparam int UNITS = TOP_BLOCKS << TOP_ORDER;
   localparam int UW    = $clog2(UNITS);
   localparam int TW    = (TOP_BLOCKS > 1) ? $clog2(TOP_BLOCKS) : 1;
   localparam int OW    = $clog2(TOP_ORDER + 1);
   localparam int MW    = TOP_ORDER + 1;
   localparam int NODES = TOP_BLOCKS * ((2 << TOP_ORDER) - 2);
   localparam int NW    = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int CW    = UW + 1;
   localparam int TREE_C = TOP_BLOCKS << (TOP_ORDER + 1);

   // Sequencer states.
   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DECODE = 4'd2;
   localparam logic [3:0] S_SCAN   = 4'd3;
   localparam logic [3:0] S_DESC   = 4'd4;
   localparam logic [3:0] S_AAPPLY = 4'd5;
   localparam logic [3:0] S_UP     = 4'd6;
   localparam logic [3:0] S_SIB    = 4'd7;
   localparam logic [3:0] S_UPRD   = 4'd8;
   localparam logic [3:0] S_FCHK   = 4'd9;
   localparam logic [3:0] S_MCHK   = 4'd10;
   localparam logic [3:0] S_MRD    = 4'd11;
   localparam logic [3:0] S_MZ     = 4'd12;
   localparam logic [3:0] S_DONE   = 4'd13;

   typedef struct packed {
      logic              used;
      logic [OW-1:0]     order;
      logic [BYTE_W-1:0] held;
   } unit_word_type;

   // Address of the tree node at a level that covers a unit; levels below the root only.
   function automatic logic [NW-1:0] naddr(input logic [OW-1:0] lvl, input logic [UW-1:0] u);
      logic [31:0] c;
      c = 32'(TREE_C);
      return NW'(c - (c >> lvl) + (32'(u) >> lvl));
   endfunction

   // Free-mask memory: per node, bit k set when a free block of order k lies inside.
   logic [TOP_ORDER-1:0] mask_mem [NODES];
   unit_word_type        unit_mem [UNITS];

   logic [3:0]        state_ff, state_in;
   logic [NW-1:0]     clr_ff, clr_in;
   logic              mode_ff, mode_in;
   logic [23:0]       size_ff, size_in;
   logic [UW-1:0]     u_ff, u_in;
   logic              idx_ok_ff, idx_ok_in;
   logic [OW-1:0]     lvl_ff, lvl_in;
   logic [OW-1:0]     ord_ff, ord_in;
   logic [OW-1:0]     o_ff, o_in;
   logic [MW-1:0]     m_ff, m_in;
   logic [TW-1:0]     t_ff, t_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic [CW-1:0]     cnt_ff [TOP_ORDER+1];
   logic [CW-1:0]     cnt_in [TOP_ORDER+1];
   logic [MW-1:0]     root_ff [TOP_BLOCKS];
   logic [MW-1:0]     root_in [TOP_BLOCKS];
   logic [BLK_W-1:0]  free_blocks_ff, free_blocks_in;
   logic [BYTE_W-1:0] free_bytes_ff, free_bytes_in;
   logic [BLK_W-1:0]  used_blocks_ff, used_blocks_in;
   logic [BYTE_W-1:0] used_bytes_ff, used_bytes_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ba_rsp_type        rsp_ff, rsp_in;

   logic                 mw_en, mr_en, uw_en, ur_en;
   logic [NW-1:0]        mw_addr, mr_addr;
   logic [TOP_ORDER-1:0] mw_data;
   logic [TOP_ORDER-1:0] mr_data_ff;
   logic [UW-1:0]        uw_addr;
   unit_word_type        uw_data;
   unit_word_type        ur_data_ff;
   logic [MW-1:0]        rdx;

   logic [OW-1:0] ord_c, fo_c, nl;
   logic          ord_ok, found_c;
   logic [39:0]   need;
   logic [UW-1:0] bit_u, nu;

   assign rdx   = MW'(mr_data_ff);
   assign bit_u = UW'(1) << lvl_ff;

   // Smallest order that holds the request plus header, and nearest non-empty order.
   always_comb begin
      need    = 40'(size_ff) + 40'(HEADER_BYTES);
      ord_c   = '0;
      ord_ok  = 1'b0;
      fo_c    = '0;
      found_c = 1'b0;
      for (int k = TOP_ORDER; k >= 0; k--) begin
         if ((40'(MIN_BLOCK_BYTES) << k) >= need) begin
            ord_c  = OW'(k);
            ord_ok = 1'b1;
         end
      end
      for (int k = TOP_ORDER; k >= 0; k--) begin
         if (OW'(k) >= ord_c && cnt_ff[k] != '0) begin
            fo_c    = OW'(k);
            found_c = 1'b1;
         end
      end
   end

   // Sequencer next-state and datapath.
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      mode_in        = mode_ff;
      size_in        = size_ff;
      u_in           = u_ff;
      idx_ok_in      = idx_ok_ff;
      lvl_in         = lvl_ff;
      ord_in         = ord_ff;
      o_in           = o_ff;
      m_in           = m_ff;
      t_in           = t_ff;
      res_status_in  = res_status_ff;
      cnt_in         = cnt_ff;
      root_in        = root_ff;
      free_blocks_in = free_blocks_ff;
      free_bytes_in  = free_bytes_ff;
      used_blocks_in = used_blocks_ff;
      used_bytes_in  = used_bytes_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff;
      mw_en          = 1'b0;
      mw_addr        = '0;
      mw_data        = '0;
      mr_en          = 1'b0;
      mr_addr        = '0;
      uw_en          = 1'b0;
      uw_addr        = u_ff;
      uw_data        = '0;
      ur_en          = 1'b0;
      nl             = lvl_ff - OW'(1);
      nu             = u_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            mw_en   = 1'b1;
            mw_addr = clr_ff;
            if (32'(clr_ff) < UNITS) begin
               uw_en   = 1'b1;
               uw_addr = UW'(clr_ff);
            end
            if (clr_ff == NW'(NODES - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + NW'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               mode_in   = req_payload.mode;
               size_in   = req_payload.request_size;
               u_in      = UW'(32'(req_payload.block_index));
               idx_ok_in = 32'(req_payload.block_index) < UNITS;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            if (mode_ff == MODE_ALLOC) begin
               if (size_ff == '0 || !ord_ok) begin
                  res_status_in = STATUS_BAD_SIZE;
                  state_in      = S_DONE;
               end else if (!found_c) begin
                  res_status_in = STATUS_NO_SPACE;
                  state_in      = S_DONE;
               end else begin
                  ord_in   = ord_c;
                  o_in     = fo_c;
                  t_in     = '0;
                  state_in = S_SCAN;
               end
            end else if (!idx_ok_ff) begin
               res_status_in = STATUS_FREE_IGNORED;
               state_in      = S_DONE;
            end else begin
               ur_en    = 1'b1;
               state_in = S_FCHK;
            end
         end
         // Walk the top blocks for the lowest one holding a free block of the order.
         S_SCAN: begin
            if (root_ff[t_ff][o_ff]) begin
               nu     = UW'(32'(t_ff) << TOP_ORDER);
               u_in   = nu;
               lvl_in = OW'(TOP_ORDER);
               if (o_ff == OW'(TOP_ORDER)) begin
                  state_in = S_AAPPLY;
               end else begin
                  mr_en    = 1'b1;
                  mr_addr  = naddr(OW'(TOP_ORDER - 1), nu);
                  state_in = S_DESC;
               end
            end else begin
               t_in = t_ff + TW'(1);
            end
         end
         // Descend one level: take the left child when it holds the order.
         S_DESC: begin
            nu     = rdx[o_ff] ? u_ff : (u_ff | (UW'(1) << nl));
            u_in   = nu;
            lvl_in = nl;
            if (nl == o_ff) begin
               state_in = S_AAPPLY;
            end else begin
               mr_en    = 1'b1;
               mr_addr  = naddr(nl - OW'(1), nu);
               state_in = S_DESC;
            end
         end
         S_AAPPLY: begin
            cnt_in[o_ff]   = cnt_ff[o_ff] - CW'(1);
            free_blocks_in = free_blocks_ff - BLK_W'(1);
            free_bytes_in  = free_bytes_ff - BYTE_W'(40'(MIN_BLOCK_BYTES) << ord_ff);
            used_blocks_in = used_blocks_ff + BLK_W'(1);
            used_bytes_in  = used_bytes_ff + size_ff[BYTE_W-1:0];
            uw_en          = 1'b1;
            uw_data.used   = 1'b1;
            uw_data.order  = ord_ff;
            uw_data.held   = size_ff[BYTE_W-1:0];
            lvl_in         = ord_ff;
            m_in           = '0;
            state_in       = S_UP;
         end
         // Write the path node's mask and gather its sibling for the parent.
         S_UP: begin
            if (lvl_ff == OW'(TOP_ORDER)) begin
               root_in[TW'(u_ff >> TOP_ORDER)] = m_ff;
               res_status_in = STATUS_OK;
               state_in      = S_DONE;
            end else begin
               mw_en   = 1'b1;
               mw_addr = naddr(lvl_ff, u_ff);
               mw_data = m_ff[TOP_ORDER-1:0];
               if (mode_ff == MODE_ALLOC && lvl_ff < o_ff) begin
                  state_in = S_SIB;
               end else begin
                  mr_en    = 1'b1;
                  mr_addr  = naddr(lvl_ff, u_ff ^ bit_u);
                  state_in = S_UPRD;
               end
            end
         end
         // The upper half of a split becomes a free block.
         S_SIB: begin
            mw_en          = 1'b1;
            mw_addr        = naddr(lvl_ff, u_ff | bit_u);
            mw_data        = TOP_ORDER'(MW'(1) << lvl_ff);
            cnt_in[lvl_ff] = cnt_ff[lvl_ff] + CW'(1);
            free_blocks_in = free_blocks_ff + BLK_W'(1);
            m_in           = m_ff | (MW'(1) << lvl_ff);
            lvl_in         = lvl_ff + OW'(1);
            state_in       = S_UP;
         end
         S_UPRD: begin
            m_in     = m_ff | rdx;
            lvl_in   = lvl_ff + OW'(1);
            state_in = S_UP;
         end
         S_FCHK: begin
            if (!ur_data_ff.used) begin
               res_status_in = STATUS_FREE_IGNORED;
               state_in      = S_DONE;
            end else begin
               used_blocks_in = used_blocks_ff - BLK_W'(1);
               used_bytes_in  = used_bytes_ff - ur_data_ff.held;
               free_blocks_in = free_blocks_ff + BLK_W'(1);
               free_bytes_in  = free_bytes_ff +
                                BYTE_W'(40'(MIN_BLOCK_BYTES) << ur_data_ff.order);
               cnt_in[ur_data_ff.order] = cnt_ff[ur_data_ff.order] + CW'(1);
               uw_en    = 1'b1;
               lvl_in   = ur_data_ff.order;
               state_in = S_MCHK;
            end
         end
         S_MCHK: begin
            if (lvl_ff == OW'(TOP_ORDER)) begin
               m_in     = MW'(1) << lvl_ff;
               state_in = S_UP;
            end else begin
               mr_en    = 1'b1;
               mr_addr  = naddr(lvl_ff, u_ff ^ bit_u);
               state_in = S_MRD;
            end
         end
         // Merge with a free buddy of the same order, or stop here.
         S_MRD: begin
            if (rdx[lvl_ff]) begin
               mw_en          = 1'b1;
               mw_addr        = naddr(lvl_ff, u_ff ^ bit_u);
               cnt_in[lvl_ff] = cnt_ff[lvl_ff] - CW'(2);
               free_blocks_in = free_blocks_ff - BLK_W'(1);
               state_in       = S_MZ;
            end else begin
               m_in     = MW'(1) << lvl_ff;
               state_in = S_UP;
            end
         end
         S_MZ: begin
            mw_en    = 1'b1;
            mw_addr  = naddr(lvl_ff, u_ff);
            cnt_in[lvl_ff + OW'(1)] = cnt_ff[lvl_ff + OW'(1)] + CW'(1);
            u_in     = u_ff & ~bit_u;
            lvl_in   = lvl_ff + OW'(1);
            state_in = S_MCHK;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.status           = res_status_ff;
               rsp_in.granted_index    = (res_status_ff == STATUS_OK && mode_ff == MODE_ALLOC) ?
                                         15'(32'(u_ff)) : '0;
               rsp_in.granted_order    = (res_status_ff == STATUS_OK && mode_ff == MODE_ALLOC) ?
                                         4'(ord_ff) : '0;
               rsp_in.free_blocks      = free_blocks_ff;
               rsp_in.free_bytes       = free_bytes_ff;
               rsp_in.allocated_blocks = used_blocks_ff;
               rsp_in.allocated_bytes  = used_bytes_ff;
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Memories with registered read data.
   always_ff @(posedge clock) begin
      if (mw_en) begin
         mask_mem[mw_addr] <= mw_data;
      end
      if (mr_en) begin
         mr_data_ff <= mask_mem[mr_addr];
      end
      if (uw_en) begin
         unit_mem[uw_addr] <= uw_data;
      end
      if (ur_en) begin
         ur_data_ff <= unit_mem[u_ff];
      end
   end

   // Control and bookkeeping registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         free_blocks_ff <= BLK_W'(TOP_BLOCKS);
         free_bytes_ff  <= BYTE_W'((40'(TOP_BLOCKS) * 40'(MIN_BLOCK_BYTES)) << TOP_ORDER);
         used_blocks_ff <= '0;
         used_bytes_ff  <= '0;
         for (int k = 0; k <= TOP_ORDER; k++) begin
            cnt_ff[k] <= (k == TOP_ORDER) ? CW'(TOP_BLOCKS) : '0;
         end
         for (int t = 0; t < TOP_BLOCKS; t++) begin
            root_ff[t] <= MW'(1) << TOP_ORDER;
         end
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         rsp_valid_ff   <= rsp_valid_in;
         free_blocks_ff <= free_blocks_in;
         free_bytes_ff  <= free_bytes_in;
         used_blocks_ff <= used_blocks_in;
         used_bytes_ff  <= used_bytes_in;
         cnt_ff         <= cnt_in;
         root_ff        <= root_in;
      end
   end

   // Working registers of the current request.
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      size_ff       <= size_in;
      u_ff          <= u_in;
      idx_ok_ff     <= idx_ok_in;
      lvl_ff        <= lvl_in;
      ord_ff        <= ord_in;
      o_ff          <= o_in;
      m_ff          <= m_in;
      t_ff          <= t_in;
      res_status_ff <= res_status_in;
      rsp_ff        <= rsp_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   // The descent never passes below the order being searched for.
   a_desc_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DESC) |-> (lvl_ff > o_ff))
      else $error("descent below target order");

   // A new response is raised only out of the completion state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside completion");

   // Requests are only taken with the sequencer at rest.
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_DECODE))
      else $error("request transfer did not start decode");
`endif

endmodule

FILE: test/ba_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the buddy allocator: watches both channels, predicts each response
// from its own copy of the block map and counters, and compares field by field.
// Depends on ba_pkg for the transfer structs and status codes.
module ba_checker
   import ba_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  ba_req_type req_payload,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  ba_rsp_type rsp_payload,
   output int         fail_count,
   output int         pending_count
);

   localparam int UNITS      = 32768;
   localparam int ROOT_LEVEL = 10;
   localparam int UNIT_BYTES = 128;
   localparam int HDR_BYTES  = 40;
   localparam int ROOTS      = 32;

   typedef enum logic [1:0] {
      UNIT_INTERIOR = 2'd0,
      UNIT_FREE     = 2'd1,
      UNIT_USED     = 2'd2
   } unit_kind_type;

   unit_kind_type unit_kind[UNITS];
   logic [3:0]    unit_level[UNITS];
   logic [16:0]   unit_held[UNITS];
   longint        free_count, free_total, used_count, used_total;
   ba_rsp_type    expected_rsp[$];

   // Counters as the response reports them, masked to the field widths.
   function automatic ba_rsp_type stamp(logic [1:0] st, int idx, int ord);
      ba_rsp_type r;
      r.status           = st;
      r.granted_index    = idx[14:0];
      r.granted_order    = ord[3:0];
      r.free_blocks      = free_count[BLK_W-1:0];
      r.free_bytes       = free_total[BYTE_W-1:0];
      r.allocated_blocks = used_count[BLK_W-1:0];
      r.allocated_bytes  = used_total[BYTE_W-1:0];
      return r;
   endfunction

   function automatic ba_rsp_type grant_block(logic [23:0] size);
      longint need;
      int     ord, o, idx, upper;
      need = longint'(size) + HDR_BYTES;
      ord = 0;
      idx = UNITS;
      if (size == 0) return stamp(STATUS_BAD_SIZE, 0, 0);
      while (ord <= ROOT_LEVEL && (longint'(UNIT_BYTES) << ord) < need) ord++;
      if (ord > ROOT_LEVEL) return stamp(STATUS_BAD_SIZE, 0, 0);
      // Lowest-address free block of the needed order, else of the nearest larger one.
      for (o = ord; o <= ROOT_LEVEL; o++) begin
         for (int i = 0; i < UNITS; i += (1 << o)) begin
            if (unit_kind[i] == UNIT_FREE && unit_level[i] == o) begin
               idx = i;
               break;
            end
         end
         if (idx < UNITS) break;
      end
      if (idx >= UNITS) return stamp(STATUS_NO_SPACE, 0, 0);
      // Split down, keeping the lower half and freeing each upper half.
      while (o > ord) begin
         o--;
         upper = idx + (1 << o);
         unit_kind[upper]  = UNIT_FREE;
         unit_level[upper] = o[3:0];
         unit_level[idx]   = o[3:0];
         free_count++;
      end
      unit_kind[idx]  = UNIT_USED;
      unit_level[idx] = ord[3:0];
      unit_held[idx]  = size[16:0];
      free_count--;
      free_total -= longint'(UNIT_BYTES) << ord;
      used_count++;
      used_total += size;
      return stamp(STATUS_OK, idx, ord);
   endfunction

   function automatic ba_rsp_type release_block(logic [14:0] start);
      int idx, ord, buddy, lo, hi;
      idx = start;
      if (unit_kind[idx] != UNIT_USED) return stamp(STATUS_FREE_IGNORED, 0, 0);
      ord = unit_level[idx];
      used_count--;
      used_total -= unit_held[idx];
      unit_kind[idx] = UNIT_FREE;
      free_count++;
      free_total += longint'(UNIT_BYTES) << ord;
      // Merge with a free buddy of the same order, level by level.
      while (ord < ROOT_LEVEL) begin
         buddy = idx ^ (1 << ord);
         if (buddy >= UNITS || unit_kind[buddy] != UNIT_FREE || unit_level[buddy] != ord)
            break;
         lo = idx < buddy ? idx : buddy;
         hi = idx < buddy ? buddy : idx;
         unit_kind[hi]  = UNIT_INTERIOR;
         unit_level[hi] = 0;
         ord++;
         unit_kind[lo]  = UNIT_FREE;
         unit_level[lo] = ord[3:0];
         free_count--;
         idx = lo;
      end
      return stamp(STATUS_OK, 0, 0);
   endfunction

   task automatic note_mismatch(string field, longint want, longint got);
      if (fail_count < 10)
         $display("mismatch %s: expected %0d, got %0d at %0t", field, want, got, $realtime);
      fail_count++;
   endtask

   initial begin
      for (int i = 0; i < UNITS; i++) begin
         unit_kind[i]  = UNIT_INTERIOR;
         unit_level[i] = 0;
         unit_held[i]  = 0;
      end
      for (int t = 0; t < ROOTS; t++) begin
         unit_kind[t << ROOT_LEVEL]  = UNIT_FREE;
         unit_level[t << ROOT_LEVEL] = ROOT_LEVEL;
      end
      free_count = ROOTS;
      free_total = longint'(ROOTS) * (UNIT_BYTES << ROOT_LEVEL);
      used_count = 0;
      used_total = 0;
      fail_count = 0;
   end

   assign pending_count = expected_rsp.size();

   // Compare each response transfer first, then predict for a request transfer.
   always @(posedge clock) begin
      ba_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected response transfer at %0t", $realtime);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (want.status != rsp_payload.status)
                  note_mismatch("status", want.status, rsp_payload.status);
               if (want.granted_index != rsp_payload.granted_index)
                  note_mismatch("granted_index", want.granted_index,
                                rsp_payload.granted_index);
               if (want.granted_order != rsp_payload.granted_order)
                  note_mismatch("granted_order", want.granted_order,
                                rsp_payload.granted_order);
               if (want.free_blocks != rsp_payload.free_blocks)
                  note_mismatch("free_blocks", want.free_blocks, rsp_payload.free_blocks);
               if (want.free_bytes != rsp_payload.free_bytes)
                  note_mismatch("free_bytes", want.free_bytes, rsp_payload.free_bytes);
               if (want.allocated_blocks != rsp_payload.allocated_blocks)
                  note_mismatch("allocated_blocks", want.allocated_blocks,
                                rsp_payload.allocated_blocks);
               if (want.allocated_bytes != rsp_payload.allocated_bytes)
                  note_mismatch("allocated_bytes", want.allocated_bytes,
                                rsp_payload.allocated_bytes);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_payload.mode == MODE_ALLOC)
               expected_rsp.push_back(grant_block(req_payload.request_size));
            else
               expected_rsp.push_back(release_block(req_payload.block_index));
         end
      end
   end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Top of the buddy allocator testbench: clock, reset, request stimulus and verdict.
// Depends on ba_pkg, buddy_allocator and the ba_checker scoreboard.
module tb;
   import ba_pkg::*;

   localparam int WATCHDOG_LIMIT = 400000;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   ba_req_type req_payload;
   logic       rsp_valid;
   logic       rsp_stall;
   ba_rsp_type rsp_payload;
   int         fail_count;
   int         pending_count;
   int         send_idle_pct;
   int         stall_pct;
   int         idle_cycles;
   logic       sent_modes[$];
   int         live_blocks[$];

   buddy_allocator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   ba_checker scoreboard (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver back-pressure at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Track granted blocks so that most frees name a live block.
   always @(posedge clock) begin
      logic was_free;
      if (!reset && rsp_valid && !rsp_stall && sent_modes.size() > 0) begin
         was_free = sent_modes.pop_front();
         if (was_free == MODE_ALLOC && rsp_payload.status == STATUS_OK)
            live_blocks.push_back(rsp_payload.granted_index);
      end
   end

   // Watchdog on cycles without any transfer; also covers the clearing pass.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // One request transfer, with random sender gaps before it.
   task automatic send_request(logic mode, logic [23:0] size, logic [14:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid                <= 1'b1;
      req_payload.mode         <= mode;
      req_payload.request_size <= size;
      req_payload.block_index  <= idx;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      sent_modes.push_back(mode);
   endtask

   task automatic send_alloc(logic [23:0] size);
      send_request(MODE_ALLOC, size, 15'($urandom));
   endtask

   task automatic send_free(logic [14:0] idx);
      send_request(MODE_FREE, 24'($urandom), idx);
   endtask

   // Mostly well-formed traffic; large_bias pushes memory toward exhaustion.
   task automatic send_random(int large_bias);
      int pick, k;
      pick = $urandom_range(99);
      if (live_blocks.size() > 0 && pick < 45) begin
         k = $urandom_range(live_blocks.size() - 1);
         send_free(15'(live_blocks[k]));
         live_blocks.delete(k);
      end else if (pick < 50) begin
         send_free(15'($urandom));
      end else if (pick < 52) begin
         send_alloc(24'd0);
      end else if (pick < 55) begin
         send_alloc(24'($urandom));
      end else if (pick < 55 + large_bias) begin
         send_alloc(24'($urandom_range(131032, 16000)));
      end else if (pick < 80) begin
         send_alloc(24'($urandom_range(300, 1)));
      end else begin
         send_alloc(24'($urandom_range(16000, 1)));
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      rsp_stall     = 1'b0;
      send_idle_pct = 12;
      stall_pct     = 86;
      idle_cycles   = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: size edges, order edges, bad frees, double free and merge.
      send_alloc(24'd0);
      send_alloc(24'd1);
      send_alloc(24'd88);
      send_alloc(24'd89);
      send_alloc(24'd131032);
      send_alloc(24'd131033);
      send_alloc(24'hFFFFFF);
      send_free(15'h7FFF);
      send_free(15'd1);
      send_free(15'd0);
      send_free(15'd0);
      send_free(15'd1);
      send_free(15'd2);
      send_alloc(24'd1000);
      send_alloc(24'd65000);
      wait_drained();
      while (live_blocks.size() > 0) send_free(15'(live_blocks.pop_front()));
      send_free(15'd1024);

      // Sender idles lightly, receiver stalls heavily.
      for (int n = 0; n < 530; n++) send_random(10);
      wait_drained();

      // The other way round, biased toward large blocks to reach exhaustion.
      send_idle_pct = 86;
      stall_pct     = 12;
      for (int n = 0; n < 530; n++) send_random(35);

      // No idling on either side.
      send_idle_pct = 0;
      stall_pct     = 0;
      for (int n = 0; n < 530; n++) send_random(15);

      wait_drained();
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
